FILE: rtl/core/spg_pkg.sv
// shared constants, command and mode codes, and the request type for the
// stepper pulse generator; no dependencies
package spg_pkg;

  localparam int unsigned TICKS_PER_MS     = 1000;
  localparam int unsigned PULSE_HIGH_TICKS = 200;
  localparam int unsigned FAST_CYCLE_TICKS = 400;

  localparam int unsigned FAST_LEN = (FAST_CYCLE_TICKS < PULSE_HIGH_TICKS) ?
                                     PULSE_HIGH_TICKS : FAST_CYCLE_TICKS;

  localparam int unsigned SUB_W    = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam int unsigned TIMER_W  = 9;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned TARGET_W = NOW_W + FRAC_W;
  localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_MODE   = 2'd1,
    CMD_SET_PERIOD = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2,
    MODE_FAST     = 2'd3
  } mode_e;

  typedef struct packed {
    logic                tick;
    logic                set_mode;
    logic                set_period;
    mode_e               mode;
    logic [PERIOD_W-1:0] period;
  } req_t;

endpackage

FILE: rtl/core/stepper_pulse_generator.sv
// top level of the stepper step/direction pulse generator
// instantiates spg_front and spg_back; uses spg_pkg
//
// The block takes one command request per clock while in_stall_o is low
// (tick, set mode, set step period) and returns one result request per
// command with the enable, direction and step pulse levels and a flag for
// a step begun on that tick. Sustained rate is one request per cycle while
// out_stall_i is low. An accepted command is written into the two-entry
// input queue; the back end pops it when the output register is free and
// updates the time base, pulse timer and forward schedule and loads the
// output register. The longest path is the forward schedule: millisecond
// increment, 40-bit target restart add and the 32-bit due compare. Input
// stall rises only when the queue is full, which happens only while the
// output is held by out_stall_i.
module stepper_pulse_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [1:0]                   mode_i,
  input  logic [spg_pkg::PERIOD_W-1:0] period_q8_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         enable_o,
  output logic                         direction_level_o,
  output logic                         pulse_o,
  output logic                         step_started_o
);
  import spg_pkg::*;

  req_t req;
  logic req_valid;
  logic req_pop;

  spg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .mode_i      (mode_i),
    .period_q8_i (period_q8_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  spg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_valid),
    .req_i             (req),
    .req_pop_o         (req_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .enable_o          (enable_o),
    .direction_level_o (direction_level_o),
    .pulse_o           (pulse_o),
    .step_started_o    (step_started_o)
  );

  // no step pulse while the driver is disabled
  a_pulse_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !enable_o) |-> !pulse_o)
    else $error("step pulse high with driver disabled");

  // a step that starts shows a high pulse level
  a_start_shows_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_started_o) |-> pulse_o)
    else $error("step started without pulse level");

  // queue fills only behind a held result
  a_full_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

endmodule

FILE: rtl/core/spg_front.sv
// front end: accepts command requests, classifies them and holds them in a
// two-entry queue for the back end; uses spg_pkg
module spg_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [1:0]               mode_i,
  input  logic [spg_pkg::PERIOD_W-1:0] period_q8_i,
  output logic                     req_valid_o,
  output spg_pkg::req_t            req_o,
  input  logic                     req_pop_i
);
  import spg_pkg::*;

  req_t       mem_q [2];
  req_t       req_in;
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push;

  always_comb begin
    req_in            = '0;
    req_in.mode       = mode_e'(mode_i);
    req_in.period     = period_q8_i;
    case (cmd_e'(command_i))
      CMD_TICK:       req_in.tick = 1'b1;
      CMD_SET_MODE:   req_in.set_mode = 1'b1;
      CMD_SET_PERIOD: req_in.set_period = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, req_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (req_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

FILE: rtl/core/spg_back.sv
// back end: applies mode and period requests, runs the time base, pulse timer
// and step scheduler on each tick request and holds the result in an output register; uses spg_pkg
module spg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  spg_pkg::req_t req_i,
  output logic          req_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          enable_o,
  output logic          direction_level_o,
  output logic          pulse_o,
  output logic          step_started_o
);
  import spg_pkg::*;

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_MS - 1);

  mode_e                req_mode_q, req_mode_d;
  mode_e                active_q, active_d;
  mode_e                am;
  logic [PERIOD_W-1:0]  period_q, period_d;
  logic                 pending_q, pending_d;
  logic [SUB_W-1:0]     sub_q, sub_d, sub_tick;
  logic [NOW_W-1:0]     now_q, now_d, now_tick;
  // schedule target kept with the rounding half already added
  logic [TARGET_W-1:0]  target_q, target_d, target_mid, restart_b;
  logic [TIMER_W-1:0]   timer_q, timer_d, timer_dec;
  logic                 enable_q, enable_d;
  logic                 dir_q, dir_d;
  logic                 pulse_q, pulse_d;
  logic                 started;
  logic                 run_ctrl;
  logic                 mode_change, adopt_fwd;

  logic out_valid_q, out_enable_q, out_dir_q, out_pulse_q, out_started_q;

  function automatic logic [TIMER_W-1:0] cycle_len(mode_e m);
    return (m == MODE_FORWARD) ? TIMER_W'(PULSE_HIGH_TICKS) : TIMER_W'(FAST_LEN);
  endfunction

  assign req_pop_o = req_valid_i && (!out_valid_q || !out_stall_i);

  assign sub_tick  = (sub_q == SUB_LAST) ? '0 : sub_q + 1'b1;
  assign now_tick  = (sub_q == SUB_LAST) ? now_q + 1'b1 : now_q;
  assign timer_dec = timer_q - 1'b1;
  assign restart_b = {now_tick, {FRAC_W{1'b0}}} + TARGET_W'(period_q)
                     + TARGET_W'(ROUND_HALF);

  assign mode_change = (req_mode_q != active_q);
  assign am          = mode_change ? req_mode_q : active_q;
  assign adopt_fwd   = mode_change && (req_mode_q == MODE_FORWARD);
  assign target_mid  = adopt_fwd ? restart_b : target_q;

  always_comb begin
    req_mode_d = req_mode_q;
    active_d   = active_q;
    period_d   = period_q;
    pending_d  = pending_q;
    sub_d      = sub_q;
    now_d      = now_q;
    target_d   = target_q;
    timer_d    = timer_q;
    enable_d   = enable_q;
    dir_d      = dir_q;
    pulse_d    = pulse_q;
    started    = 1'b0;
    run_ctrl   = 1'b0;

    if (req_i.set_mode) begin
      req_mode_d = req_i.mode;
    end
    if (req_i.set_period) begin
      period_d  = req_i.period;
      pending_d = 1'b1;
    end

    if (req_i.tick) begin
      sub_d = sub_tick;
      now_d = now_tick;
      if (timer_q != '0) begin
        timer_d = timer_dec;
        if (({1'b0, timer_dec} + (TIMER_W+1)'(PULSE_HIGH_TICKS))
            <= {1'b0, cycle_len(active_q)}) begin
          pulse_d = 1'b0;
        end
        if (timer_dec == '0) begin
          pulse_d  = 1'b0;
          run_ctrl = 1'b1;
        end
      end else begin
        run_ctrl = 1'b1;
      end
    end

    if (run_ctrl) begin
      if (mode_change) begin
        active_d = req_mode_q;
        case (req_mode_q)
          MODE_STOP: begin
            enable_d = 1'b0;
          end
          MODE_BACKWARD: begin
            enable_d = 1'b1;
            dir_d    = 1'b0;
          end
          default: begin
            enable_d = 1'b1;
            dir_d    = 1'b1;
          end
        endcase
      end
      case (am)
        MODE_STOP: ;
        MODE_FORWARD: begin
          if (pending_q) begin
            target_d  = restart_b;
            pending_d = 1'b0;
          end else if (now_tick >= target_mid[TARGET_W-1:FRAC_W]) begin
            pulse_d  = 1'b1;
            timer_d  = cycle_len(am);
            target_d = target_mid + TARGET_W'(period_q);
            started  = 1'b1;
          end else begin
            target_d = target_mid;
          end
        end
        default: begin
          pulse_d = 1'b1;
          timer_d = cycle_len(am);
          started = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_mode_q <= MODE_STOP;
      active_q   <= MODE_STOP;
      period_q   <= '0;
      pending_q  <= 1'b0;
      sub_q      <= '0;
      now_q      <= '0;
      target_q   <= TARGET_W'(ROUND_HALF);
      timer_q    <= '0;
      enable_q   <= 1'b0;
      dir_q      <= 1'b0;
      pulse_q    <= 1'b0;
    end else if (req_pop_o) begin
      req_mode_q <= req_mode_d;
      active_q   <= active_d;
      period_q   <= period_d;
      pending_q  <= pending_d;
      sub_q      <= sub_d;
      now_q      <= now_d;
      target_q   <= target_d;
      timer_q    <= timer_d;
      enable_q   <= enable_d;
      dir_q      <= dir_d;
      pulse_q    <= pulse_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      out_enable_q  <= enable_d;
      out_dir_q     <= dir_d;
      out_pulse_q   <= pulse_d;
      out_started_q <= started;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign enable_o          = out_enable_q;
  assign direction_level_o = out_dir_q;
  assign pulse_o           = out_pulse_q;
  assign step_started_o    = out_started_q;

endmodule
